@@ rtl/tcw_pkg.sv @@
// Package for the text console writer: screen geometry, cell codes,
// kind codes and the request struct that drives the cell RAM.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS    = 80;
  localparam int LAST_ROW   = 24;
  localparam int ROW_COUNT  = LAST_ROW + 1;
  localparam int CELL_COUNT = COLUMNS * ROW_COUNT;
  localparam int COPY_COUNT = COLUMNS * LAST_ROW;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // Field widths fixed by the ports.
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = CHAR_W + ATTR_W;

  // Character and attribute codes.
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
  localparam logic [CHAR_W-1:0] RETURN_CODE  = 8'h0d;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0f;

  // Item kinds.
  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Write-port and read-port requests to the cell RAM, as driven in each cycle.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // Linear cell address of a row and column.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(row) * ADDR_W'(COLUMNS);
    return base + ADDR_W'(col);
  endfunction

endpackage

@@ rtl/text_console_writer.sv @@
// Top level of the text console writer: sequencer for put, scroll, clear
// and cell read over the cell RAM. Depends on tcw_pkg and tcw_cell_ram.
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// input     in_valid / in_stall     kind, char_code, read_row, read_col
// output    out_valid / out_stall   cell_char, cell_attr, cursor_col, cursor_row
// config    attr_we                 attr_wdata (text attribute)
//
// A put, newline, return or read beat passes through accept (with the
// character write), cell read, and result load into the output register.
// A scroll adds a copy of rows 1 and up through the single RAM read
// port, then a blank of the last row; a clear adds a blank of every cell.
// After reset a clearing pass over all CELL_COUNT cells runs with
// in_stall high. A result waiting under out_stall holds the next beat in
// the result stage until the output register frees.

module text_console_writer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  kind,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
  input  logic [tcw_pkg::ROW_W-1:0]   read_row,
  input  logic [tcw_pkg::COL_W-1:0]   read_col,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tcw_pkg::CHAR_W-1:0]  cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]  cell_attr,
  output logic [tcw_pkg::COL_W-1:0]   cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]   cursor_row,
  input  logic                        attr_we,
  input  logic [tcw_pkg::ATTR_W-1:0]  attr_wdata
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCROLL = 5'b00010,
    ST_BLANK  = 5'b00100,
    ST_READ   = 5'b01000,
    ST_RESP   = 5'b10000
  } state_t;

  state_t                        state;
  logic [tcw_pkg::ADDR_W-1:0]    cnt;
  logic                          sweep_item;
  logic [tcw_pkg::ATTR_W-1:0]    blank_attr;
  logic [tcw_pkg::ATTR_W-1:0]    text_attribute;
  logic [tcw_pkg::COL_W-1:0]     cur_col;
  logic [tcw_pkg::ROW_W-1:0]     cur_row;
  logic                          copy_valid;
  logic [tcw_pkg::ADDR_W-1:0]    copy_addr;
  logic [tcw_pkg::ROW_W-1:0]     req_row;
  logic [tcw_pkg::COL_W-1:0]     req_col;
  logic                          rd_zero;

  tcw_pkg::ram_req_t             ram_req;
  logic [tcw_pkg::CELL_W-1:0]    rd_data;

  logic                          accept;
  logic                          put_write;
  logic                          is_newline;
  logic [tcw_pkg::COL_W:0]       col_inc;
  logic                          read_in_range;
  logic                          out_free;

  assign in_stall = (state != ST_IDLE);
  assign accept   = (state == ST_IDLE) && in_valid;
  assign out_free = !out_valid || !out_stall;

  // Decode of the accepted beat.
  assign is_newline = (kind == tcw_pkg::KIND_PUT) && (char_code == tcw_pkg::NEWLINE_CODE);
  assign put_write  = (kind == tcw_pkg::KIND_PUT) && (char_code != tcw_pkg::NEWLINE_CODE)
                      && (char_code != tcw_pkg::RETURN_CODE);
  assign col_inc    = {1'b0, cur_col} + (tcw_pkg::COL_W+1)'(1);

  assign read_in_range = (req_row <= tcw_pkg::ROW_W'(tcw_pkg::LAST_ROW))
                         && ({1'b0, req_col} < (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS));

  // RAM requests for each state.
  always_comb begin
    ram_req       = '0;
    ram_req.waddr = cnt;
    ram_req.wdata = {blank_attr, tcw_pkg::BLANK_CHAR};
    ram_req.raddr = cnt + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
    case (state)
      ST_IDLE: begin
        ram_req.we    = accept && put_write;
        ram_req.waddr = tcw_pkg::cell_addr(cur_row, cur_col);
        ram_req.wdata = {text_attribute, char_code};
      end
      ST_SCROLL: begin
        ram_req.re    = (cnt < tcw_pkg::ADDR_W'(tcw_pkg::COPY_COUNT));
        ram_req.we    = copy_valid;
        ram_req.waddr = copy_addr;
        ram_req.wdata = rd_data;
      end
      ST_BLANK: begin
        ram_req.we = 1'b1;
      end
      ST_READ: begin
        ram_req.re    = read_in_range;
        ram_req.raddr = tcw_pkg::cell_addr(req_row, req_col);
      end
      default: begin
        ram_req.we = 1'b0;
      end
    endcase
  end

  tcw_cell_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // Sequencer, cursor and configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_BLANK;
      cnt            <= '0;
      sweep_item     <= 1'b0;
      blank_attr     <= tcw_pkg::RESET_ATTR;
      text_attribute <= tcw_pkg::RESET_ATTR;
      cur_col        <= '0;
      cur_row        <= '0;
      copy_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (attr_we) begin
        text_attribute <= attr_wdata;
      end
      // The result register fills from the result stage and empties when taken.
      if ((state == ST_RESP) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      copy_valid <= (state == ST_SCROLL)
                    && (cnt < tcw_pkg::ADDR_W'(tcw_pkg::COPY_COUNT));
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            blank_attr <= text_attribute;
            sweep_item <= 1'b1;
            cnt        <= '0;
            if (kind == tcw_pkg::KIND_CLEAR) begin
              cur_col <= '0;
              cur_row <= '0;
              state   <= ST_BLANK;
            end else if (is_newline
                         || (put_write && col_inc >= (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS))) begin
              // Move to the start of the next line, scrolling at the bottom.
              cur_col <= '0;
              if (cur_row >= tcw_pkg::ROW_W'(tcw_pkg::LAST_ROW)) begin
                cur_row <= tcw_pkg::ROW_W'(tcw_pkg::LAST_ROW);
                state   <= ST_SCROLL;
              end else begin
                cur_row <= cur_row + tcw_pkg::ROW_W'(1);
                state   <= ST_READ;
              end
            end else begin
              if (put_write) begin
                cur_col <= col_inc[tcw_pkg::COL_W-1:0];
              end
              state <= ST_READ;
            end
          end
        end
        ST_SCROLL: begin
          // Copy row r+1 into row r; the write comes in the cycle after its read.
          copy_addr <= cnt;
          if (cnt == tcw_pkg::ADDR_W'(tcw_pkg::COPY_COUNT)) begin
            state <= ST_BLANK;
          end else begin
            cnt <= cnt + tcw_pkg::ADDR_W'(1);
          end
        end
        ST_BLANK: begin
          if (cnt == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1)) begin
            state <= sweep_item ? ST_READ : ST_IDLE;
          end else begin
            cnt <= cnt + tcw_pkg::ADDR_W'(1);
          end
        end
        ST_READ: begin
          state <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Request capture and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_row <= read_row;
      req_col <= read_col;
    end
    if (state == ST_READ) begin
      rd_zero <= !read_in_range;
    end
    if ((state == ST_RESP) && out_free) begin
      cell_char  <= rd_zero ? '0 : rd_data[tcw_pkg::CHAR_W-1:0];
      cell_attr  <= rd_zero ? '0 : rd_data[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
      cursor_col <= cur_col;
      cursor_row <= cur_row;
    end
  end

endmodule

@@ rtl/tcw_cell_ram.sv @@
// Cell store of the text console: one write port and one read port,
// read data registered. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_cell_ram (
  input  logic                          clk,
  input  tcw_pkg::ram_req_t             req,
  output logic [tcw_pkg::CELL_W-1:0]    rd_data
);

  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

@@ dv/tcw_checker.sv @@
// Checker for the text console writer: keeps its own copy of the screen,
// cursor and attribute, predicts every result beat and compares it.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_checker
  import tcw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        kind,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [ROW_W-1:0]  read_row,
  input  logic [COL_W-1:0]  read_col,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [CHAR_W-1:0] cell_char,
  input  logic [ATTR_W-1:0] cell_attr,
  input  logic [COL_W-1:0]  cursor_col,
  input  logic [ROW_W-1:0]  cursor_row,
  input  logic              attr_we,
  input  logic [ATTR_W-1:0] attr_wdata,
  output int                pending,
  output int                fail_count
);

  // One result beat: the requested cell and the cursor after the step.
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic [ATTR_W-1:0] attr;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } cell_report_t;

  logic [CELL_W-1:0] screen [CELL_COUNT];
  int                cur_col;
  int                cur_row;
  logic [ATTR_W-1:0] attr_reg;
  cell_report_t      reports_due[$];
  int                errors = 0;

  function automatic logic [CELL_W-1:0] blank_cell();
    return {attr_reg, BLANK_CHAR};
  endfunction

  // Clear fills every cell with a blank and homes the cursor.
  function automatic void blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) screen[i] = blank_cell();
    cur_col = 0;
    cur_row = 0;
  endfunction

  // Rows 1 and up move up by one; the bottom row becomes blanks.
  function automatic void scroll_screen();
    for (int i = 0; i < COPY_COUNT; i++) screen[i] = screen[i + COLUMNS];
    for (int i = COPY_COUNT; i < CELL_COUNT; i++) screen[i] = blank_cell();
  endfunction

  function automatic void new_line();
    cur_col = 0;
    if (cur_row >= LAST_ROW) begin
      cur_row = LAST_ROW;
      scroll_screen();
    end else begin
      cur_row++;
    end
  endfunction

  // Applies one request beat to the screen and returns the result it must give.
  function automatic cell_report_t step_console(input logic [1:0]        k,
                                                input logic [CHAR_W-1:0] ch,
                                                input logic [ROW_W-1:0]  rr,
                                                input logic [COL_W-1:0]  rc);
    int               pos;
    logic [CELL_W-1:0] cell_word;
    cell_report_t     rep;
    cell_word = '0;
    case (k)
      KIND_PUT: begin
        if (ch == NEWLINE_CODE) begin
          new_line();
        end else if (ch != RETURN_CODE) begin
          pos = cur_row * COLUMNS + cur_col;
          if (pos < CELL_COUNT) screen[pos] = {attr_reg, ch};
          cur_col++;
          if (cur_col >= COLUMNS) new_line();
        end
      end
      KIND_CLEAR: begin
        blank_screen();
      end
      default: begin
        // A read, or the spare kind code, leaves everything as it is.
      end
    endcase
    // Positions off the screen read back as zero.
    if (int'(rr) <= LAST_ROW && int'(rc) < COLUMNS) begin
      cell_word = screen[int'(rr) * COLUMNS + int'(rc)];
    end
    rep.ch   = cell_word[CHAR_W-1:0];
    rep.attr = cell_word[CELL_W-1:CHAR_W];
    rep.col  = COL_W'(cur_col);
    rep.row  = ROW_W'(cur_row);
    return rep;
  endfunction

  // Compares a result beat with the oldest prediction, field by field.
  task automatic check_report(input cell_report_t got);
    cell_report_t want;
    if (reports_due.size() == 0) begin
      $error("result beat with no request outstanding");
      errors++;
    end else begin
      want = reports_due.pop_front();
      if (got.ch !== want.ch) begin
        $error("cell_char: expected %02h, got %02h", want.ch, got.ch);
        errors++;
      end
      if (got.attr !== want.attr) begin
        $error("cell_attr: expected %02h, got %02h", want.attr, got.attr);
        errors++;
      end
      if (got.col !== want.col) begin
        $error("cursor_col: expected %0d, got %0d", want.col, got.col);
        errors++;
      end
      if (got.row !== want.row) begin
        $error("cursor_row: expected %0d, got %0d", want.row, got.row);
        errors++;
      end
    end
  endtask

  // Results are checked before new requests are queued, since a result
  // always belongs to an earlier beat.
  always @(posedge clk) begin
    if (rst) begin
      attr_reg = RESET_ATTR;
      blank_screen();
      reports_due.delete();
    end else begin
      if (out_valid && !out_stall) check_report('{cell_char, cell_attr, cursor_col, cursor_row});
      if (attr_we) attr_reg = attr_wdata;
      if (in_valid && !in_stall) begin
        reports_due.push_back(step_console(kind, char_code, read_row, read_col));
      end
    end
    pending    <= reports_due.size();
    fail_count <= errors;
  end

endmodule

@@ dv/tb_top.sv @@
// Top of the text console writer testbench: clock, reset, request beats,
// attribute writes, result stall pattern and verdict.
// Depends on tcw_pkg, text_console_writer and tcw_checker.
`timescale 1ns / 1ps

module tb_top;
  import tcw_pkg::*;

  localparam logic [1:0] KIND_SPARE      = 2'd3;
  localparam int         PHASES          = 7;
  localparam int         ITEMS_PER_PHASE = 90;
  localparam int         WATCHDOG_LIMIT  = 12000;
  localparam int         SETTLE_CYCLES   = 40;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        kind;
  logic [CHAR_W-1:0] char_code;
  logic [ROW_W-1:0]  read_row;
  logic [COL_W-1:0]  read_col;
  logic              out_valid;
  logic              out_stall;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attr;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic              attr_we;
  logic [ATTR_W-1:0] attr_wdata;

  int pending;
  int fail_count;
  int idle_cycles = 0;
  int burst_left  = 0;
  int gap_max     = 8;
  int line_left   = 0;
  int stall_mode  = 0;
  int stall_left  = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  text_console_writer i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .char_code  (char_code),
    .read_row   (read_row),
    .read_col   (read_col),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .attr_we    (attr_we),
    .attr_wdata (attr_wdata)
  );

  tcw_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .char_code  (char_code),
    .read_row   (read_row),
    .read_col   (read_col),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .attr_we    (attr_we),
    .attr_wdata (attr_wdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  // Result stall: patterns drawn at random in turn, from none at all
  // to light and heavy random stalls and periodic stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(30, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ((stall_left % 5) < 2);
    endcase
  end

  // Watchdog: ends the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no beat accepted for %0d cycles", idle_cycles);
      $display("** text_console_writer: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one request beat until it is taken, then maybe ends the burst.
  task automatic send_beat(input logic [1:0]        k,
                           input logic [CHAR_W-1:0] ch,
                           input logic [ROW_W-1:0]  rr,
                           input logic [COL_W-1:0]  rc);
    int gap;
    in_valid  <= 1'b1;
    kind      <= k;
    char_code <= ch;
    read_row  <= rr;
    read_col  <= rc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Holds off new requests until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_attr(input logic [ATTR_W-1:0] value);
    drain();
    attr_we    <= 1'b1;
    attr_wdata <= value;
    @(posedge clk);
    attr_we    <= 1'b0;
  endtask

  // Mostly short lines so that the cursor reaches the bottom and scrolls;
  // now and then a line long enough to wrap.
  function automatic int pick_line_len();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 15) return $urandom_range(0, 4);
    if (sel < 19) return $urandom_range(5, 30);
    return $urandom_range(70, 100);
  endfunction

  // Draws one random request: text lines, with reads, returns, the spare
  // kind code and the odd clear mixed in.
  task automatic random_beat(output logic [1:0]        k,
                             output logic [CHAR_W-1:0] ch,
                             output logic [ROW_W-1:0]  rr,
                             output logic [COL_W-1:0]  rc);
    int sel;
    sel = $urandom_range(0, 399);
    ch  = CHAR_W'($urandom_range(0, 255));
    k   = KIND_PUT;
    if (sel < 16) begin
      k = KIND_READ;
    end else if (sel < 24) begin
      k = KIND_SPARE;
    end else if (sel == 24) begin
      k = KIND_CLEAR;
    end else if (sel < 36) begin
      ch = RETURN_CODE;
    end else if (line_left == 0) begin
      ch = NEWLINE_CODE;
      line_left = pick_line_len();
    end else begin
      if ($urandom_range(0, 3) != 0) ch = CHAR_W'($urandom_range(8'h20, 8'h7e));
      line_left--;
    end
    // Reads lean toward the lower rows, where scrolled text ends up.
    sel = $urandom_range(0, 9);
    if (sel < 5) rr = ROW_W'($urandom_range(0, LAST_ROW));
    else if (sel < 8) rr = ROW_W'($urandom_range(LAST_ROW - 6, LAST_ROW));
    else rr = ROW_W'($urandom_range(0, 31));
    if ($urandom_range(0, 19) < 17) rc = COL_W'($urandom_range(0, COLUMNS - 1));
    else rc = COL_W'($urandom_range(0, 127));
  endtask

  initial begin
    logic [1:0]        k;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  rr;
    logic [COL_W-1:0]  rc;
    rst        = 1'b1;
    in_valid   = 1'b0;
    kind       = KIND_PUT;
    char_code  = '0;
    read_row   = '0;
    read_col   = '0;
    attr_we    = 1'b0;
    attr_wdata = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed beats under the reset attribute: blank screen, odd bytes,
    // return, newline, spare kind, reads off the screen, clear.
    send_beat(KIND_READ,  8'h00,        5'd0,  7'd0);
    send_beat(KIND_PUT,   8'h48,        5'd0,  7'd0);
    send_beat(KIND_PUT,   8'h00,        5'd0,  7'd1);
    send_beat(KIND_PUT,   8'hff,        5'd0,  7'd2);
    send_beat(KIND_PUT,   RETURN_CODE,  5'd0,  7'd3);
    send_beat(KIND_PUT,   NEWLINE_CODE, 5'd0,  7'd0);
    send_beat(KIND_PUT,   8'h7e,        5'd1,  7'd0);
    send_beat(KIND_SPARE, 8'h41,        5'd1,  7'd0);
    send_beat(KIND_READ,  8'hff,        5'd24, 7'd79);
    send_beat(KIND_READ,  8'h00,        5'd25, 7'd0);
    send_beat(KIND_READ,  8'h00,        5'd31, 7'd127);
    send_beat(KIND_READ,  8'h00,        5'd0,  7'd80);
    send_beat(KIND_READ,  8'hff,        5'd0,  7'd127);
    send_beat(KIND_PUT,   8'h20,        5'd0,  7'd2);
    send_beat(KIND_CLEAR, 8'h41,        5'd0,  7'd0);
    send_beat(KIND_READ,  8'h00,        5'd1,  7'd0);
    send_beat(KIND_PUT,   NEWLINE_CODE, 5'd1,  7'd0);
    send_beat(KIND_PUT,   8'h80,        5'd1,  7'd0);

    // Random phases, each under its own attribute; one runs without gaps.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: write_attr(8'h00);
        1: write_attr(8'hff);
        2: write_attr(8'h5a);
        3: write_attr(8'ha5);
        4: write_attr(RESET_ATTR);
        default: write_attr(ATTR_W'($urandom_range(0, 255)));
      endcase
      gap_max = (phase == 2) ? 0 : 8;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        random_beat(k, ch, rr, rc);
        send_beat(k, ch, rr, rc);
        if ($urandom_range(0, 99) == 0) drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** text_console_writer: PASSED **");
    end else begin
      if (pending != 0) $error("%0d results never arrived", pending);
      $display("** text_console_writer: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tcw_pkg.sv
rtl/tcw_cell_ram.sv
rtl/text_console_writer.sv
dv/tcw_checker.sv
dv/tb_top.sv
